### design/selective_repeat_sender_window_core_assert.svh
// Assertion macros shared by the sender window core.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRSW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRSW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/srsw_pkg.sv
// Types, codes and fixed widths of the selective-repeat sender window.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srsw_pkg;
	localparam int MAX_CHUNKS = 4096;
	localparam int ID_W = 12;
	localparam int CNT_W = 13;
	localparam int SIZE_W = 17;
	localparam int OFF_W = 29;
	localparam int RET_W = 8;
	localparam int TIME_W = 32;
	localparam int NREP_W = 4;
	localparam int RESULT_CAP = 8;
	localparam int TIMEOUT_BASE = 5000;
	localparam int TIMEOUT_STEP = 100;
	localparam int MAX_SIZE = 65536;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_SEND = 3'd1;
	localparam logic [2:0] KIND_RETX = 3'd2;
	localparam logic [2:0] KIND_ACK = 3'd3;
	localparam logic [2:0] KIND_IGN = 3'd4;

	localparam logic [1:0] FUNC_SEND = 2'd0;
	localparam logic [1:0] FUNC_ACK = 2'd1;
	localparam logic [1:0] FUNC_SCAN = 2'd2;

	localparam logic [1:0] CFG_TOTAL = 2'd0;
	localparam logic [1:0] CFG_SIZE = 2'd1;
	localparam logic [1:0] CFG_FILE = 2'd2;
	localparam logic [1:0] CFG_CKPT = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [11:0] ack_chunk;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [11:0] chunk_num;
		logic [31:0] chunk_offset;
		logic [16:0] chunk_len;
		logic [7:0]  retries;
		logic [31:0] bytes_done;
		logic        checkpoint_due;
		logic        transfer_done;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] sent;
		logic [RET_W-1:0]  ret;
	} flight_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [RET_W-1:0] ret;
	} queue_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLEAR, OP_CAPTURE, OP_RD_NEXT, OP_NEXT_INC, OP_PUSH_NEW, OP_POP,
		OP_RES_NONE, OP_RES_IGN, OP_RD_ACK, OP_MARK, OP_DIV_CK, OP_CK_SAVE, OP_DIV_FS,
		OP_ACK_UPD, OP_ACK_DROP, OP_KEEP, OP_REPORT, OP_FLT_END, OP_EMIT_MID, OP_EMIT_LAST
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_SKIP_RD, ST_SKIP_CHK, ST_REFILL, ST_POP,
		ST_RES_NONE, ST_RES_IGN, ST_ACK_RD, ST_ACK_CHK, ST_ACK_MARK, ST_DIV_CK,
		ST_WAIT_CK, ST_CK_SAVE, ST_DIV_FS, ST_WAIT_FS, ST_ACK_UPD, ST_FLT_WALK,
		ST_SCAN, ST_FLT_END, ST_EMIT_MID, ST_EMIT_LAST
	} state_t;

	typedef struct packed {
		logic       clr_done;
		logic       out_free;
		logic       busy_full;
		logic       q_empty;
		logic       id_bad;
		logic       ram_bit;
		logic       next_end;
		logic       refill_more;
		logic       div_busy;
		logic       last_chunk;
		logic       walk_end;
		logic       find_hit;
		logic       scan_hit;
		logic       pend_v;
		logic [1:0] func;
	} status_t;
endpackage
`default_nettype wire

### design/selective_repeat_sender_window_core.sv
// Top level of the selective-repeat sender window core.
// Depends on srsw_pkg, srsw_ctrl, srsw_dp and the assertion macro header.

// After reset the acknowledgement bitmap is cleared, during which no item is taken;
// configuration writes are accepted at any time. Items are handled one at a time
// by a controller that steps the datapath. A send request pops a queued chunk; when the
// queue is empty, a refill first skips acknowledged chunks and then queues new chunks.
// An acknowledgement walks the in-flight entries, and for the last chunk it runs a second
// division, since the checkpoint and last-chunk byte counts each use the remainder unit.
// A scan walks the in-flight entries and reports timed-out ones as retransmissions. A result
// that is not taken holds the controller until the output register is free. The output
// register lets the next item start while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_sender_window_core_assert.svh"
module selective_repeat_sender_window_core #(
	parameter int WINDOW = 8,
	parameter int REFILL_BATCH = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire srsw_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output srsw_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);
	srsw_pkg::op_t     op;
	srsw_pkg::status_t stat;

	srsw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.stat(stat),
		.op(op),
		.in_ready(in_ready)
	);

	srsw_dp #(
		.WINDOW(WINDOW),
		.REFILL_BATCH(REFILL_BATCH),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data(out_data),
		.stat(stat)
	);

	`SRSW_ASSERT_NEXT(a_leave_idle, in_valid && in_ready, !in_ready, "ready held after transfer")
	`SRSW_ASSERT_NOW(a_capture_hs, op == srsw_pkg::OP_CAPTURE, in_valid && in_ready,
		"capture without input transfer")
	`SRSW_ASSERT_NOW(a_emit_free, op == srsw_pkg::OP_EMIT_MID || op == srsw_pkg::OP_EMIT_LAST,
		stat.out_free, "result loaded over a pending one")
endmodule
`default_nettype wire

### design/srsw_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module srsw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### design/srsw_rem.sv
// Iterative remainder unit, one dividend bit per cycle over the 32-bit dividend.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module srsw_rem (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dvd,
	input  wire logic [16:0] dvs,
	output logic             busy,
	output logic      [16:0] rem
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [16:0] dvs_q;
	logic [16:0] rem_q;
	logic [17:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q, dvd_q[31]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd;
			dvs_q <= dvs;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[16:0];
			end else begin
				rem_q <= trial[16:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

### design/srsw_dp.sv
// Datapath of the sender window: registers, bitmap, queue, flight table, output.
// Depends on srsw_pkg, srsw_ram and srsw_rem.
`timescale 1ns / 1ps
`default_nettype none
module srsw_dp #(
	parameter int WINDOW = 8,
	parameter int REFILL_BATCH = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srsw_pkg::op_t      op,
	input  wire srsw_pkg::in_item_t in_data,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output srsw_pkg::out_item_t     out_data,
	output srsw_pkg::status_t       stat
);
	localparam int FIW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam int QIW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int BW = $clog2(REFILL_BATCH + 1);
	localparam int AW = $clog2(srsw_pkg::MAX_CHUNKS);

	logic [srsw_pkg::CNT_W-1:0]  total_q;
	logic [srsw_pkg::SIZE_W-1:0] csize_q;
	logic [31:0]                 fsize_q;
	logic [15:0]                 ckev_q;

	logic [1:0]                  func_q;
	logic [srsw_pkg::ID_W-1:0]   ack_q;
	logic [31:0]                 now_q;

	logic [srsw_pkg::CNT_W-1:0]  next_q;
	logic [srsw_pkg::CNT_W-1:0]  acnt_q;
	logic [31:0]                 abytes_q;
	logic                        active_q;
	logic [CW-1:0]               fcnt_q;
	logic [CW-1:0]               rd_q;
	logic [CW-1:0]               wr_q;
	logic [QIW-1:0]              head_q;
	logic [QCW-1:0]              qcnt_q;
	logic [AW-1:0]               clr_q;
	logic [srsw_pkg::NREP_W-1:0] nrep_q;
	logic [BW-1:0]               fill_q;
	logic                        found_q;
	logic                        pend_q;
	logic                        out_valid_q;

	srsw_pkg::flight_t flt_q [WINDOW];
	srsw_pkg::queue_t  que_q [QUEUE_DEPTH];

	logic [2:0]                  res_kind_q;
	logic [srsw_pkg::ID_W-1:0]   res_id_q;
	logic [srsw_pkg::RET_W-1:0]  res_ret_q;
	logic [srsw_pkg::OFF_W-1:0]  res_off_q;
	logic [srsw_pkg::SIZE_W-1:0] res_bytes_q;
	logic                        res_ckpt_q;
	srsw_pkg::out_item_t         out_q;

	logic [srsw_pkg::CNT_W-1:0]  eff_total;
	logic [srsw_pkg::SIZE_W-1:0] eff_size;
	srsw_pkg::flight_t           cur;
	srsw_pkg::queue_t            head_ent;
	logic [31:0]                 elapsed;
	logic [15:0]                 limit;
	logic                        timed;
	logic [QCW:0]                tail_sum;
	logic [QIW-1:0]              tail;
	logic [QIW-1:0]              head_dec;
	logic [QIW-1:0]              head_inc;
	logic [srsw_pkg::ID_W-1:0]   mul_id;
	logic [srsw_pkg::OFF_W-1:0]  prod;
	logic [srsw_pkg::RET_W-1:0]  ret_inc;
	logic [srsw_pkg::SIZE_W-1:0] ack_bytes;
	logic [srsw_pkg::SIZE_W-1:0] send_len;
	logic [32:0]                 off_end;
	logic                        ram_we;
	logic [AW-1:0]               ram_addr;
	logic                        ram_wdata;
	logic                        ram_rdata;
	logic                        div_start;
	logic [31:0]                 div_dvd;
	logic [16:0]                 div_dvs;
	logic                        div_busy;
	logic [16:0]                 div_rem;
	logic                        emit;
	logic                        last_chunk;

	always_comb begin
		if (total_q > srsw_pkg::CNT_W'(srsw_pkg::MAX_CHUNKS)) begin
			eff_total = srsw_pkg::CNT_W'(srsw_pkg::MAX_CHUNKS);
		end else begin
			eff_total = total_q;
		end
		if (csize_q == '0) begin
			eff_size = srsw_pkg::SIZE_W'(1);
		end else if (csize_q > srsw_pkg::SIZE_W'(srsw_pkg::MAX_SIZE)) begin
			eff_size = srsw_pkg::SIZE_W'(srsw_pkg::MAX_SIZE);
		end else begin
			eff_size = csize_q;
		end
	end

	assign cur = flt_q[rd_q[FIW-1:0]];
	assign head_ent = que_q[head_q];
	assign elapsed = now_q - cur.sent;
	assign limit = 16'(srsw_pkg::TIMEOUT_BASE) + 16'(cur.ret) * 16'(srsw_pkg::TIMEOUT_STEP);
	assign timed = elapsed > {16'd0, limit};
	assign tail_sum = {1'b0, head_q} + {1'b0, qcnt_q};
	assign tail = (tail_sum >= (QCW + 1)'(QUEUE_DEPTH)) ?
		QIW'(tail_sum - (QCW + 1)'(QUEUE_DEPTH)) : QIW'(tail_sum);
	assign head_dec = (head_q == '0) ? QIW'(QUEUE_DEPTH - 1) : head_q - QIW'(1);
	assign head_inc = (head_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIW'(1);
	assign ret_inc = (cur.ret == '1) ? cur.ret : cur.ret + srsw_pkg::RET_W'(1);
	assign last_chunk = {1'b0, ack_q} == (eff_total - srsw_pkg::CNT_W'(1));
	assign emit = (op == srsw_pkg::OP_EMIT_MID) || (op == srsw_pkg::OP_EMIT_LAST);

	always_comb begin
		case (op)
			srsw_pkg::OP_POP: mul_id = head_ent.id;
			srsw_pkg::OP_REPORT: mul_id = cur.id;
			default: mul_id = ack_q;
		endcase
	end
	assign prod = srsw_pkg::OFF_W'(mul_id) * srsw_pkg::OFF_W'(eff_size);

	always_comb begin
		if (last_chunk) begin
			ack_bytes = (div_rem == '0) ? eff_size : div_rem;
		end else begin
			ack_bytes = eff_size;
		end
		off_end = {4'd0, res_off_q} + {16'd0, eff_size};
		if ({3'd0, res_off_q} >= fsize_q) begin
			send_len = '0;
		end else if (off_end > {1'b0, fsize_q}) begin
			send_len = srsw_pkg::SIZE_W'(fsize_q - {3'd0, res_off_q});
		end else begin
			send_len = eff_size;
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wdata = 1'b0;
		ram_addr = next_q[AW-1:0];
		case (op)
			srsw_pkg::OP_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
			end
			srsw_pkg::OP_RD_ACK: ram_addr = ack_q;
			srsw_pkg::OP_MARK: begin
				ram_we = 1'b1;
				ram_wdata = 1'b1;
				ram_addr = ack_q;
			end
			default: ram_addr = next_q[AW-1:0];
		endcase
	end

	srsw_ram #(
		.WIDTH(1),
		.DEPTH(srsw_pkg::MAX_CHUNKS)
	) u_done_map (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_comb begin
		div_start = (op == srsw_pkg::OP_DIV_CK) || (op == srsw_pkg::OP_DIV_FS);
		if (op == srsw_pkg::OP_DIV_FS) begin
			div_dvd = fsize_q;
			div_dvs = eff_size;
		end else begin
			div_dvd = {19'd0, acnt_q};
			div_dvs = {1'b0, ckev_q};
		end
	end

	srsw_rem u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dvd(div_dvd),
		.dvs(div_dvs),
		.busy(div_busy),
		.rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			csize_q <= srsw_pkg::SIZE_W'(1024);
			fsize_q <= '0;
			ckev_q <= 16'd16;
			next_q <= '0;
			acnt_q <= '0;
			abytes_q <= '0;
			active_q <= 1'b1;
			fcnt_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			head_q <= '0;
			qcnt_q <= '0;
			clr_q <= '0;
			nrep_q <= '0;
			fill_q <= '0;
			found_q <= 1'b0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					srsw_pkg::CFG_TOTAL: total_q <= cfg_data[12:0];
					srsw_pkg::CFG_SIZE: csize_q <= cfg_data[16:0];
					srsw_pkg::CFG_FILE: fsize_q <= cfg_data;
					srsw_pkg::CFG_CKPT: ckev_q <= cfg_data[15:0];
					default: ckev_q <= ckev_q;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				pend_q <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				srsw_pkg::OP_CLEAR: clr_q <= clr_q + AW'(1);
				srsw_pkg::OP_CAPTURE: begin
					rd_q <= '0;
					wr_q <= '0;
					nrep_q <= '0;
					fill_q <= '0;
					found_q <= 1'b0;
					pend_q <= 1'b0;
				end
				srsw_pkg::OP_NEXT_INC: next_q <= next_q + srsw_pkg::CNT_W'(1);
				srsw_pkg::OP_PUSH_NEW: begin
					next_q <= next_q + srsw_pkg::CNT_W'(1);
					fill_q <= fill_q + BW'(1);
					qcnt_q <= qcnt_q + QCW'(1);
				end
				srsw_pkg::OP_POP: begin
					head_q <= head_inc;
					qcnt_q <= qcnt_q - QCW'(1);
					fcnt_q <= fcnt_q + CW'(1);
				end
				srsw_pkg::OP_MARK: begin
					if (acnt_q != '1) begin
						acnt_q <= acnt_q + srsw_pkg::CNT_W'(1);
					end
				end
				srsw_pkg::OP_ACK_UPD: begin
					abytes_q <= abytes_q + 32'(ack_bytes);
					if (acnt_q >= eff_total) begin
						active_q <= 1'b0;
					end
				end
				srsw_pkg::OP_ACK_DROP: begin
					rd_q <= rd_q + CW'(1);
					found_q <= 1'b1;
				end
				srsw_pkg::OP_KEEP: begin
					rd_q <= rd_q + CW'(1);
					wr_q <= wr_q + CW'(1);
				end
				srsw_pkg::OP_REPORT: begin
					rd_q <= rd_q + CW'(1);
					nrep_q <= nrep_q + srsw_pkg::NREP_W'(1);
					head_q <= head_dec;
					qcnt_q <= qcnt_q + QCW'(1);
					pend_q <= 1'b1;
				end
				srsw_pkg::OP_FLT_END: fcnt_q <= wr_q;
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			srsw_pkg::OP_CAPTURE: begin
				func_q <= in_data.func;
				ack_q <= in_data.ack_chunk;
				now_q <= in_data.now_ms;
			end
			srsw_pkg::OP_PUSH_NEW: begin
				que_q[tail].id <= next_q[srsw_pkg::ID_W-1:0];
				que_q[tail].ret <= '0;
			end
			srsw_pkg::OP_POP: begin
				flt_q[fcnt_q[FIW-1:0]].id <= head_ent.id;
				flt_q[fcnt_q[FIW-1:0]].sent <= now_q;
				flt_q[fcnt_q[FIW-1:0]].ret <= head_ent.ret;
				res_kind_q <= srsw_pkg::KIND_SEND;
				res_id_q <= head_ent.id;
				res_ret_q <= head_ent.ret;
				res_off_q <= prod;
				res_ckpt_q <= 1'b0;
			end
			srsw_pkg::OP_RES_NONE: begin
				res_kind_q <= srsw_pkg::KIND_NONE;
				res_id_q <= '0;
				res_ret_q <= '0;
				res_ckpt_q <= 1'b0;
			end
			srsw_pkg::OP_RES_IGN: begin
				res_kind_q <= srsw_pkg::KIND_IGN;
				res_id_q <= ack_q;
				res_ret_q <= '0;
				res_ckpt_q <= 1'b0;
			end
			srsw_pkg::OP_MARK: res_off_q <= prod;
			srsw_pkg::OP_CK_SAVE: res_ckpt_q <= (ckev_q != '0) && (div_rem == '0);
			srsw_pkg::OP_ACK_UPD: begin
				res_kind_q <= srsw_pkg::KIND_ACK;
				res_id_q <= ack_q;
				res_ret_q <= '0;
				res_bytes_q <= ack_bytes;
			end
			srsw_pkg::OP_KEEP: flt_q[wr_q[FIW-1:0]] <= cur;
			srsw_pkg::OP_REPORT: begin
				que_q[head_dec].id <= cur.id;
				que_q[head_dec].ret <= ret_inc;
				res_kind_q <= srsw_pkg::KIND_RETX;
				res_id_q <= cur.id;
				res_ret_q <= ret_inc;
				res_off_q <= prod;
				res_ckpt_q <= 1'b0;
			end
			default: res_ckpt_q <= res_ckpt_q;
		endcase
		if (emit) begin
			out_q.kind <= res_kind_q;
			out_q.chunk_num <= res_id_q;
			out_q.retries <= res_ret_q;
			out_q.bytes_done <= abytes_q;
			out_q.checkpoint_due <= res_ckpt_q;
			out_q.transfer_done <= !active_q;
			out_q.last <= (op == srsw_pkg::OP_EMIT_LAST);
			case (res_kind_q)
				srsw_pkg::KIND_SEND, srsw_pkg::KIND_RETX: begin
					out_q.chunk_offset <= {3'd0, res_off_q};
					out_q.chunk_len <= send_len;
				end
				srsw_pkg::KIND_ACK: begin
					out_q.chunk_offset <= {3'd0, res_off_q};
					out_q.chunk_len <= res_bytes_q;
				end
				default: begin
					out_q.chunk_offset <= '0;
					out_q.chunk_len <= '0;
				end
			endcase
		end
	end

	always_comb begin
		stat.clr_done = (clr_q == '1);
		stat.out_free = !out_valid_q || out_ready;
		stat.busy_full = !active_q || (fcnt_q >= CW'(WINDOW));
		stat.q_empty = (qcnt_q == '0);
		stat.id_bad = ({1'b0, ack_q} >= eff_total);
		stat.ram_bit = ram_rdata;
		stat.next_end = (next_q >= eff_total);
		stat.refill_more = (fill_q < BW'(REFILL_BATCH)) && (next_q < eff_total) &&
			(qcnt_q != QCW'(QUEUE_DEPTH));
		stat.div_busy = div_busy;
		stat.last_chunk = last_chunk;
		stat.walk_end = (rd_q == fcnt_q);
		stat.find_hit = !found_q && (cur.id == ack_q);
		stat.scan_hit = timed && (nrep_q < srsw_pkg::NREP_W'(srsw_pkg::RESULT_CAP)) &&
			(qcnt_q != QCW'(QUEUE_DEPTH));
		stat.pend_v = pend_q;
		stat.func = func_q;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule
`default_nettype wire

### design/srsw_ctrl.sv
// Controller state machine of the sender window; issues one datapath command a cycle.
// Depends on srsw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srsw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire srsw_pkg::status_t stat,
	output srsw_pkg::op_t          op,
	output logic                   in_ready
);
	srsw_pkg::state_t state_q;
	srsw_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srsw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			srsw_pkg::ST_CLEAR: if (stat.clr_done) state_nx = srsw_pkg::ST_IDLE;
			srsw_pkg::ST_IDLE: if (in_valid) state_nx = srsw_pkg::ST_DISPATCH;
			srsw_pkg::ST_DISPATCH: begin
				case (stat.func)
					srsw_pkg::FUNC_SEND: begin
						if (stat.busy_full) begin
							state_nx = srsw_pkg::ST_RES_NONE;
						end else if (stat.q_empty) begin
							state_nx = srsw_pkg::ST_SKIP_RD;
						end else begin
							state_nx = srsw_pkg::ST_POP;
						end
					end
					srsw_pkg::FUNC_ACK: begin
						state_nx = stat.id_bad ? srsw_pkg::ST_RES_IGN : srsw_pkg::ST_ACK_RD;
					end
					srsw_pkg::FUNC_SCAN: state_nx = srsw_pkg::ST_SCAN;
					default: state_nx = srsw_pkg::ST_RES_NONE;
				endcase
			end
			srsw_pkg::ST_SKIP_RD: begin
				state_nx = stat.next_end ? srsw_pkg::ST_REFILL : srsw_pkg::ST_SKIP_CHK;
			end
			srsw_pkg::ST_SKIP_CHK: begin
				state_nx = stat.ram_bit ? srsw_pkg::ST_SKIP_RD : srsw_pkg::ST_REFILL;
			end
			srsw_pkg::ST_REFILL: begin
				if (!stat.refill_more) begin
					state_nx = stat.q_empty ? srsw_pkg::ST_RES_NONE : srsw_pkg::ST_POP;
				end
			end
			srsw_pkg::ST_POP: state_nx = srsw_pkg::ST_EMIT_LAST;
			srsw_pkg::ST_RES_NONE: state_nx = srsw_pkg::ST_EMIT_LAST;
			srsw_pkg::ST_RES_IGN: state_nx = srsw_pkg::ST_EMIT_LAST;
			srsw_pkg::ST_ACK_RD: state_nx = srsw_pkg::ST_ACK_CHK;
			srsw_pkg::ST_ACK_CHK: begin
				state_nx = stat.ram_bit ? srsw_pkg::ST_RES_IGN : srsw_pkg::ST_ACK_MARK;
			end
			srsw_pkg::ST_ACK_MARK: state_nx = srsw_pkg::ST_DIV_CK;
			srsw_pkg::ST_DIV_CK: state_nx = srsw_pkg::ST_WAIT_CK;
			srsw_pkg::ST_WAIT_CK: if (!stat.div_busy) state_nx = srsw_pkg::ST_CK_SAVE;
			srsw_pkg::ST_CK_SAVE: begin
				state_nx = stat.last_chunk ? srsw_pkg::ST_DIV_FS : srsw_pkg::ST_ACK_UPD;
			end
			srsw_pkg::ST_DIV_FS: state_nx = srsw_pkg::ST_WAIT_FS;
			srsw_pkg::ST_WAIT_FS: if (!stat.div_busy) state_nx = srsw_pkg::ST_ACK_UPD;
			srsw_pkg::ST_ACK_UPD: state_nx = srsw_pkg::ST_FLT_WALK;
			srsw_pkg::ST_FLT_WALK: if (stat.walk_end) state_nx = srsw_pkg::ST_FLT_END;
			srsw_pkg::ST_SCAN: begin
				if (stat.walk_end) begin
					state_nx = srsw_pkg::ST_FLT_END;
				end else if (stat.scan_hit && stat.pend_v) begin
					state_nx = srsw_pkg::ST_EMIT_MID;
				end
			end
			srsw_pkg::ST_FLT_END: begin
				if (stat.func == srsw_pkg::FUNC_SCAN && !stat.pend_v) begin
					state_nx = srsw_pkg::ST_RES_NONE;
				end else begin
					state_nx = srsw_pkg::ST_EMIT_LAST;
				end
			end
			srsw_pkg::ST_EMIT_MID: if (stat.out_free) state_nx = srsw_pkg::ST_SCAN;
			srsw_pkg::ST_EMIT_LAST: if (stat.out_free) state_nx = srsw_pkg::ST_IDLE;
			default: state_nx = srsw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		op = srsw_pkg::OP_NOP;
		in_ready = 1'b0;
		case (state_q)
			srsw_pkg::ST_CLEAR: op = srsw_pkg::OP_CLEAR;
			srsw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = srsw_pkg::OP_CAPTURE;
			end
			srsw_pkg::ST_SKIP_RD: op = srsw_pkg::OP_RD_NEXT;
			srsw_pkg::ST_SKIP_CHK: if (stat.ram_bit) op = srsw_pkg::OP_NEXT_INC;
			srsw_pkg::ST_REFILL: if (stat.refill_more) op = srsw_pkg::OP_PUSH_NEW;
			srsw_pkg::ST_POP: op = srsw_pkg::OP_POP;
			srsw_pkg::ST_RES_NONE: op = srsw_pkg::OP_RES_NONE;
			srsw_pkg::ST_RES_IGN: op = srsw_pkg::OP_RES_IGN;
			srsw_pkg::ST_ACK_RD: op = srsw_pkg::OP_RD_ACK;
			srsw_pkg::ST_ACK_MARK: op = srsw_pkg::OP_MARK;
			srsw_pkg::ST_DIV_CK: op = srsw_pkg::OP_DIV_CK;
			srsw_pkg::ST_CK_SAVE: op = srsw_pkg::OP_CK_SAVE;
			srsw_pkg::ST_DIV_FS: op = srsw_pkg::OP_DIV_FS;
			srsw_pkg::ST_ACK_UPD: op = srsw_pkg::OP_ACK_UPD;
			srsw_pkg::ST_FLT_WALK: begin
				if (!stat.walk_end) begin
					op = stat.find_hit ? srsw_pkg::OP_ACK_DROP : srsw_pkg::OP_KEEP;
				end
			end
			srsw_pkg::ST_SCAN: begin
				if (!stat.walk_end) begin
					if (!stat.scan_hit) begin
						op = srsw_pkg::OP_KEEP;
					end else if (!stat.pend_v) begin
						op = srsw_pkg::OP_REPORT;
					end
				end
			end
			srsw_pkg::ST_FLT_END: op = srsw_pkg::OP_FLT_END;
			srsw_pkg::ST_EMIT_MID: if (stat.out_free) op = srsw_pkg::OP_EMIT_MID;
			srsw_pkg::ST_EMIT_LAST: if (stat.out_free) op = srsw_pkg::OP_EMIT_LAST;
			default: op = srsw_pkg::OP_NOP;
		endcase
	end
endmodule
`default_nettype wire
